[rtl/utsx_pkg.sv]
// Shared types and constants of the UTF-8 text statistics engine.
package utsx_pkg;

   localparam int COUNT_BITS_DEF    = 32;
   localparam int FRACTION_BITS_DEF = 16;
   localparam int CNT_OUT_W         = 32;
   localparam int MEAN_W            = 48;
   localparam int SHARE_W           = 17;
   localparam int WIDE_W            = 80;

   localparam logic [MEAN_W-1:0]  MEAN_MAX  = '1;
   localparam logic [SHARE_W-1:0] SHARE_MAX = '1;

   localparam logic [7:0] MASK_CONT  = 8'hC0;
   localparam logic [7:0] CODE_CONT  = 8'h80;
   localparam logic [7:0] MASK_LEAD2 = 8'hE0;
   localparam logic [7:0] MASK_LEAD3 = 8'hF0;
   localparam logic [7:0] MASK_LEAD4 = 8'hF8;
   localparam logic [7:0] CODE_LEAD2 = 8'hC0;
   localparam logic [7:0] CODE_LEAD3 = 8'hE0;
   localparam logic [7:0] CODE_LEAD4 = 8'hF0;

   localparam logic [20:0] CP_TAB      = 21'h09;
   localparam logic [20:0] CP_LF       = 21'h0A;
   localparam logic [20:0] CP_VT       = 21'h0B;
   localparam logic [20:0] CP_FF       = 21'h0C;
   localparam logic [20:0] CP_CR       = 21'h0D;
   localparam logic [20:0] CP_SPACE    = 21'h20;
   localparam logic [20:0] CP_BANG     = 21'h21;
   localparam logic [20:0] CP_DQUOTE   = 21'h22;
   localparam logic [20:0] CP_SQUOTE   = 21'h27;
   localparam logic [20:0] CP_DOT      = 21'h2E;
   localparam logic [20:0] CP_QMARK    = 21'h3F;
   localparam logic [20:0] CP_USCORE   = 21'h5F;
   localparam logic [20:0] CP_IDEO_SP  = 21'h3000;
   localparam logic [20:0] CP_IDEO_DOT = 21'h3002;
   localparam logic [20:0] CP_FW_BANG  = 21'hFF01;
   localparam logic [20:0] CP_FW_QMARK = 21'hFF1F;
   localparam logic [20:0] CP_LDQUOTE  = 21'h201C;
   localparam logic [20:0] CP_CORNER   = 21'h300C;
   localparam logic [20:0] CP_WCORNER  = 21'h300E;

   typedef struct packed {
      logic latch;
      logic flush;
      logic decode;
      logic finish;
      logic div_start;
      logic div_sel;
      logic load;
   } dp_cmd_type;

   typedef struct packed {
      logic pend_any;
      logic byte_cont;
      logic div_done;
   } dp_status_type;

   typedef struct packed {
      logic [CNT_OUT_W-1:0] codepoint_count;
      logic [CNT_OUT_W-1:0] sentences;
      logic [CNT_OUT_W-1:0] tokens;
      logic [CNT_OUT_W-1:0] filled_lines;
      logic [CNT_OUT_W-1:0] quoted_lines;
      logic [MEAN_W-1:0]    mean_sentence_tokens;
      logic [SHARE_W-1:0]   quoted_line_share;
   } result_type;

endpackage

[rtl/utsx_if.sv]
// Word channels of the engine: text bytes in, statistics out.
interface utsx_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       byte_valid;
   logic       end_of_text;
   modport source (output valid, data_byte, byte_valid, end_of_text, input ready);
   modport sink (input valid, data_byte, byte_valid, end_of_text, output ready);
endinterface

interface utsx_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] codepoint_count;
   logic [31:0] sentences;
   logic [31:0] tokens;
   logic [31:0] filled_lines;
   logic [31:0] quoted_lines;
   logic [47:0] mean_sentence_tokens;
   logic [16:0] quoted_line_share;
   modport source (output valid, codepoint_count, sentences, tokens, filled_lines,
                   quoted_lines, mean_sentence_tokens, quoted_line_share, input ready);
   modport sink (input valid, codepoint_count, sentences, tokens, filled_lines,
                 quoted_lines, mean_sentence_tokens, quoted_line_share, output ready);
endinterface

[rtl/utsx_div.sv]
// Restoring divider, one quotient bit per cycle, giving floor(num * 2^F / den).
module utsx_div #(
   parameter int COUNT_BITS    = 32,
   parameter int FRACTION_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [COUNT_BITS-1:0]               num,
   input  logic [COUNT_BITS-1:0]               den,
   output logic                                done,
   output logic [COUNT_BITS+FRACTION_BITS-1:0] quotient
);
   localparam int QW = COUNT_BITS + FRACTION_BITS;
   localparam int CW = $clog2(QW + 1);

   logic [QW-1:0]         quo_ff, quo_in;
   logic [COUNT_BITS-1:0] rem_ff, rem_in, den_ff, den_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic                  busy_ff, busy_in, done_ff, done_in;
   logic [COUNT_BITS:0]   shifted;
   logic                  fits;

   always_comb begin
      shifted = {rem_ff, quo_ff[QW-1]};
      fits    = shifted >= {1'b0, den_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = QW'(num) << FRACTION_BITS;
         rem_in  = '0;
         den_in  = den;
         cnt_in  = CW'(QW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[QW-2:0], fits};
         rem_in = fits ? COUNT_BITS'(shifted - {1'b0, den_ff}) : shifted[COUNT_BITS-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

[rtl/utsx_dp.sv]
// Datapath: byte classifier, lenient UTF-8 decoder, saturating counters, result registers.
module utsx_dp #(
   parameter int COUNT_BITS    = 32,
   parameter int FRACTION_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  utsx_pkg::dp_cmd_type    cmd,
   output utsx_pkg::dp_status_type status,
   input  logic [7:0]              data_byte,
   input  logic                    byte_valid,
   output utsx_pkg::result_type    result
);
   import utsx_pkg::*;

   localparam int CB = COUNT_BITS;
   localparam int QW = COUNT_BITS + FRACTION_BITS;

   function automatic logic [CB-1:0] sat_inc(input logic [CB-1:0] v);
      return (&v) ? v : v + 1'b1;
   endfunction

   function automatic logic [CNT_OUT_W-1:0] to_out(input logic [CB-1:0] v);
      logic [WIDE_W-1:0] w;
      w = WIDE_W'(v);
      return w[CNT_OUT_W-1:0];
   endfunction

   function automatic logic is_space(input logic [20:0] c);
      return c == CP_SPACE || c == CP_TAB || c == CP_LF || c == CP_VT ||
             c == CP_FF || c == CP_CR;
   endfunction

   logic [7:0]    byte_ff;
   logic [7:0]    pend_ff [3];
   logic [7:0]    pend_in [3];
   logic [1:0]    pc_ff, pc_in, pn_ff, pn_in, fidx_ff, fidx_in;
   logic [CB-1:0] cp_tot_ff, cp_tot_in, sent_ff, sent_in, word_ff, word_in;
   logic [CB-1:0] space_ff, space_in, filled_ff, filled_in, quoted_ff, quoted_in;
   logic [CB-1:0] tokens_ff, tokens_in;
   logic          sopen_ff, sopen_in, inword_ff, inword_in, inspace_ff, inspace_in;
   logic          content_ff, content_in, decided_ff, decided_in, lquote_ff, lquote_in;
   logic          sel_ff, zero_ff;
   logic [MEAN_W-1:0]  mean_ff;
   logic [SHARE_W-1:0] share_ff;
   result_type    res_ff;

   logic          take_en, take_mark, line_end;
   logic [20:0]   take_cp;
   logic          term, ws, bword;
   logic [20:0]   bcp;

   logic               div_done;
   logic [QW-1:0]      div_q;
   logic [CB-1:0]      div_num, div_den;
   logic [WIDE_W-1:0]  q_wide;

   assign div_num = cmd.div_sel ? quoted_ff : tokens_ff;
   assign div_den = cmd.div_sel ? filled_ff : sent_ff;

   utsx_div #(.COUNT_BITS(COUNT_BITS), .FRACTION_BITS(FRACTION_BITS)) u_div (
      .clock(clock), .reset(reset), .start(cmd.div_start),
      .num(div_num), .den(div_den), .done(div_done), .quotient(div_q)
   );

   always_comb begin
      pend_in    = pend_ff;
      pc_in      = pc_ff;
      pn_in      = pn_ff;
      fidx_in    = fidx_ff;
      cp_tot_in  = cp_tot_ff;
      sent_in    = sent_ff;
      word_in    = word_ff;
      space_in   = space_ff;
      filled_in  = filled_ff;
      quoted_in  = quoted_ff;
      tokens_in  = tokens_ff;
      sopen_in   = sopen_ff;
      inword_in  = inword_ff;
      inspace_in = inspace_ff;
      content_in = content_ff;
      decided_in = decided_ff;
      lquote_in  = lquote_ff;
      take_en    = 1'b0;
      take_mark  = 1'b1;
      take_cp    = '0;
      line_end   = 1'b0;
      bcp        = 21'(data_byte);
      bword      = (data_byte >= 8'h30 && data_byte <= 8'h39) ||
                   (data_byte >= 8'h41 && data_byte <= 8'h5A) ||
                   (data_byte >= 8'h61 && data_byte <= 8'h7A) ||
                   bcp == CP_USCORE || bcp == CP_SQUOTE;

      if (cmd.latch && byte_valid) begin
         if (bword && !inword_ff) word_in = sat_inc(word_ff);
         inword_in = bword;
         if (!is_space(bcp)) begin
            if (!inspace_ff) space_in = sat_inc(space_ff);
            inspace_in = 1'b1;
            content_in = 1'b1;
         end else begin
            inspace_in = 1'b0;
         end
      end

      if (cmd.flush) begin
         take_en = 1'b1;
         take_cp = 21'(pend_ff[fidx_ff]);
         if (fidx_ff == pc_ff - 1'b1) begin
            pc_in   = '0;
            pn_in   = '0;
            fidx_in = '0;
         end else begin
            fidx_in = fidx_ff + 1'b1;
         end
      end

      if (cmd.decode) begin
         if (pc_ff != '0) begin
            // Only a continuation byte reaches here with a sequence open.
            if (pc_ff >= pn_ff || pc_ff == 2'd3) begin
               take_en = 1'b1;
               case (pn_ff)
                  2'd1: take_cp = 21'({pend_ff[0][4:0], byte_ff[5:0]});
                  2'd2: take_cp = 21'({pend_ff[0][3:0], pend_ff[1][5:0], byte_ff[5:0]});
                  default: take_cp = {pend_ff[0][2:0], pend_ff[1][5:0], pend_ff[2][5:0],
                                      byte_ff[5:0]};
               endcase
               pc_in = '0;
               pn_in = '0;
            end else begin
               pend_in[pc_ff] = byte_ff;
               pc_in          = pc_ff + 1'b1;
            end
         end else if (!byte_ff[7]) begin
            take_en   = 1'b1;
            take_cp   = 21'(byte_ff);
            take_mark = 21'(byte_ff) != CP_LF;
            line_end  = 21'(byte_ff) == CP_LF;
         end else if ((byte_ff & MASK_LEAD2) == CODE_LEAD2 ||
                      (byte_ff & MASK_LEAD3) == CODE_LEAD3 ||
                      (byte_ff & MASK_LEAD4) == CODE_LEAD4) begin
            pn_in      = ((byte_ff & MASK_LEAD2) == CODE_LEAD2) ? 2'd1 :
                         ((byte_ff & MASK_LEAD3) == CODE_LEAD3) ? 2'd2 : 2'd3;
            pend_in[0] = byte_ff;
            pc_in      = 2'd1;
         end else begin
            take_en = 1'b1;
            take_cp = 21'(byte_ff);
         end
      end

      term = take_cp == CP_DOT || take_cp == CP_BANG || take_cp == CP_QMARK ||
             take_cp == CP_IDEO_DOT || take_cp == CP_FW_BANG || take_cp == CP_FW_QMARK;
      ws   = is_space(take_cp) || take_cp == CP_IDEO_SP;
      if (take_en) begin
         cp_tot_in = sat_inc(cp_tot_ff);
         if (term) begin
            if (sopen_ff) sent_in = sat_inc(sent_ff);
            sopen_in = 1'b0;
         end else if (!ws) begin
            sopen_in = 1'b1;
         end
         if (take_mark && !decided_ff &&
             !(take_cp == CP_SPACE || take_cp == CP_TAB || take_cp == CP_CR ||
               take_cp == CP_IDEO_SP)) begin
            decided_in = 1'b1;
            lquote_in  = take_cp == CP_DQUOTE || take_cp == CP_SQUOTE ||
                         take_cp == CP_LDQUOTE || take_cp == CP_CORNER ||
                         take_cp == CP_WCORNER;
         end
      end

      if (cmd.finish) begin
         if (sopen_ff) sent_in = sat_inc(sent_ff);
         sopen_in  = 1'b0;
         line_end  = 1'b1;
         tokens_in = (word_ff != '0) ? word_ff : space_ff;
      end

      if (line_end) begin
         if (content_ff) begin
            filled_in = sat_inc(filled_ff);
            if (lquote_ff) quoted_in = sat_inc(quoted_ff);
         end
         content_in = 1'b0;
         decided_in = 1'b0;
         lquote_in  = 1'b0;
      end
   end

   assign q_wide = WIDE_W'(div_q);

   always_ff @(posedge clock) begin
      if (cmd.latch) byte_ff <= data_byte;
      pend_ff <= pend_in;
      if (cmd.div_start) begin
         sel_ff  <= cmd.div_sel;
         zero_ff <= div_den == '0;
      end
      if (div_done && !sel_ff) begin
         mean_ff <= zero_ff ? '0 :
                    (q_wide > WIDE_W'(MEAN_MAX)) ? MEAN_MAX : q_wide[MEAN_W-1:0];
      end
      if (div_done && sel_ff) begin
         share_ff <= zero_ff ? '0 :
                     (q_wide > WIDE_W'(SHARE_MAX)) ? SHARE_MAX : q_wide[SHARE_W-1:0];
      end
      if (cmd.load) begin
         res_ff.codepoint_count      <= to_out(cp_tot_ff);
         res_ff.sentences            <= to_out(sent_ff);
         res_ff.tokens               <= to_out(tokens_ff);
         res_ff.filled_lines         <= to_out(filled_ff);
         res_ff.quoted_lines         <= to_out(quoted_ff);
         res_ff.mean_sentence_tokens <= mean_ff;
         res_ff.quoted_line_share    <= share_ff;
      end
      if (reset || cmd.load) begin
         pc_ff      <= '0;
         pn_ff      <= '0;
         fidx_ff    <= '0;
         cp_tot_ff  <= '0;
         sent_ff    <= '0;
         word_ff    <= '0;
         space_ff   <= '0;
         filled_ff  <= '0;
         quoted_ff  <= '0;
         tokens_ff  <= '0;
         sopen_ff   <= 1'b0;
         inword_ff  <= 1'b0;
         inspace_ff <= 1'b0;
         content_ff <= 1'b0;
         decided_ff <= 1'b0;
         lquote_ff  <= 1'b0;
      end else begin
         pc_ff      <= pc_in;
         pn_ff      <= pn_in;
         fidx_ff    <= fidx_in;
         cp_tot_ff  <= cp_tot_in;
         sent_ff    <= sent_in;
         word_ff    <= word_in;
         space_ff   <= space_in;
         filled_ff  <= filled_in;
         quoted_ff  <= quoted_in;
         tokens_ff  <= tokens_in;
         sopen_ff   <= sopen_in;
         inword_ff  <= inword_in;
         inspace_ff <= inspace_in;
         content_ff <= content_in;
         decided_ff <= decided_in;
         lquote_ff  <= lquote_in;
      end
   end

   assign status.pend_any  = pc_ff != '0;
   assign status.byte_cont = (byte_ff & MASK_CONT) == CODE_CONT;
   assign status.div_done  = div_done;
   assign result           = res_ff;

   // An open sequence always knows its length and never outgrows it.
   a_pend_len: assert property (@(posedge clock) disable iff (reset)
      pc_ff != '0 |-> (pn_ff != '0 && pc_ff <= pn_ff))
      else $error("pending count inconsistent with sequence length");
   // A text is finished only once every pending byte has been flushed.
   a_finish_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> pc_ff == '0)
      else $error("text finished with bytes still pending");
   a_load_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (cp_tot_ff == '0 && !sopen_ff && !content_ff))
      else $error("state not cleared after result load");
endmodule

[rtl/utsx_ctrl.sv]
// Controller: sequences decode, flush, finish, the two divisions and the result handoff.
module utsx_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_byte_valid,
   input  logic                    req_end_of_text,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  utsx_pkg::dp_status_type status,
   output utsx_pkg::dp_cmd_type    cmd
);
   import utsx_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE, ST_DEC, ST_END, ST_DIV_A, ST_WAIT_A, ST_DIV_B, ST_WAIT_B, ST_OUT
   } state_type;

   state_type state_ff;
   logic      eot_ff, rvalid_ff;
   logic      out_free;

   assign out_free  = !rvalid_ff || rsp_ready;
   assign req_ready = state_ff == ST_IDLE;
   assign rsp_valid = rvalid_ff;

   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_IDLE:  cmd.latch     = req_valid;
         ST_DEC: begin
            cmd.flush  = status.pend_any && !status.byte_cont;
            cmd.decode = !(status.pend_any && !status.byte_cont);
         end
         ST_END: begin
            cmd.flush  = status.pend_any;
            cmd.finish = !status.pend_any;
         end
         ST_DIV_A: cmd.div_start = 1'b1;
         ST_DIV_B: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = 1'b1;
         end
         ST_OUT:   cmd.load      = out_free;
         default:  cmd           = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         eot_ff    <= 1'b0;
         rvalid_ff <= 1'b0;
      end else begin
         if (cmd.load) rvalid_ff <= 1'b1;
         else if (rsp_ready) rvalid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  eot_ff <= req_end_of_text;
                  if (req_byte_valid) state_ff <= ST_DEC;
                  else if (req_end_of_text) state_ff <= ST_END;
               end
            end
            ST_DEC: begin
               if (!(status.pend_any && !status.byte_cont))
                  state_ff <= eot_ff ? ST_END : ST_IDLE;
            end
            ST_END: begin
               if (!status.pend_any) state_ff <= ST_DIV_A;
            end
            ST_DIV_A:  state_ff <= ST_WAIT_A;
            ST_WAIT_A: if (status.div_done) state_ff <= ST_DIV_B;
            ST_DIV_B:  state_ff <= ST_WAIT_B;
            ST_WAIT_B: if (status.div_done) state_ff <= ST_OUT;
            ST_OUT: begin
               if (out_free) state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end
endmodule

[rtl/utsx_if_dummy_guard.sv]
// Checker on the port side: results appear only after an end-of-text word was taken.
module utsx_chk (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic req_end_of_text,
   input logic rsp_valid,
   input logic rsp_ready
);
   logic open_ff;

   // A text stays open from its end-of-text word until the block takes words again.
   always_ff @(posedge clock) begin
      if (reset) open_ff <= 1'b0;
      else if (req_valid && req_ready && req_end_of_text) open_ff <= 1'b1;
      else if (req_ready) open_ff <= 1'b0;
   end

   a_rsp_after_eot: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(open_ff))
      else $error("result without end of text");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      open_ff && !rsp_valid |-> !req_ready)
      else $error("word accepted while result computed");
endmodule

[rtl/utf8_text_statistics_engine_top.sv]
// Bytes in, one statistics word out per text. Each byte is accepted, then decoded, and
// each byte of a broken sequence that must be flushed is taken in turn. End of text
// flushes up to three pending bytes, finishes the text, runs two serial divisions in one
// shared restoring divider and loads the result register;
// the next text may start while that result waits to be taken.
module utf8_text_statistics_engine_top #(
   parameter int COUNT_BITS    = utsx_pkg::COUNT_BITS_DEF,
   parameter int FRACTION_BITS = utsx_pkg::FRACTION_BITS_DEF
) (
   input logic      clock,
   input logic      reset,
   utsx_req_if.sink req_chan,
   utsx_rsp_if.source rsp_chan
);
   import utsx_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;
   result_type    result;

   utsx_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_chan.valid), .req_byte_valid(req_chan.byte_valid),
      .req_end_of_text(req_chan.end_of_text), .req_ready(req_chan.ready),
      .rsp_valid(rsp_chan.valid), .rsp_ready(rsp_chan.ready),
      .status(status), .cmd(cmd)
   );

   utsx_dp #(.COUNT_BITS(COUNT_BITS), .FRACTION_BITS(FRACTION_BITS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status),
      .data_byte(req_chan.data_byte), .byte_valid(req_chan.byte_valid), .result(result)
   );

   utsx_chk u_chk (
      .clock(clock), .reset(reset),
      .req_valid(req_chan.valid), .req_ready(req_chan.ready),
      .req_end_of_text(req_chan.end_of_text),
      .rsp_valid(rsp_chan.valid), .rsp_ready(rsp_chan.ready)
   );

   assign rsp_chan.codepoint_count      = result.codepoint_count;
   assign rsp_chan.sentences            = result.sentences;
   assign rsp_chan.tokens               = result.tokens;
   assign rsp_chan.filled_lines         = result.filled_lines;
   assign rsp_chan.quoted_lines         = result.quoted_lines;
   assign rsp_chan.mean_sentence_tokens = result.mean_sentence_tokens;
   assign rsp_chan.quoted_line_share    = result.quoted_line_share;
endmodule

[tb/utsx_tb_checker.sv]
// Checker for the text statistics engine: predicts each statistics word and compares it.
module utsx_tb_checker (
   input logic clock,
   input logic reset,
   utsx_req_if req_chan,
   utsx_rsp_if rsp_chan,
   output int fail_count,
   output int pending_words
);
   timeunit 1ns;
   timeprecision 1ps;
   import utsx_pkg::*;

   localparam int FRAC = FRACTION_BITS_DEF;
   localparam logic [63:0] CNT_MAX = 64'hFFFF_FFFF;

   logic [7:0]  pend_bytes [3];
   int          pend_count;
   int          pend_needed;
   logic [63:0] cp_total, sent_total, word_total, space_total, filled_total, quoted_total;
   logic        sent_open, in_word, in_space, line_content, marker_done, line_quoted;

   result_type stats_queue [$];

   function automatic logic [63:0] bump(input logic [63:0] v);
      return (v >= CNT_MAX) ? CNT_MAX : v + 1;
   endfunction

   function automatic logic is_blank(input logic [20:0] b);
      return b == CP_SPACE || b == CP_TAB || b == CP_LF || b == CP_VT || b == CP_FF ||
             b == CP_CR;
   endfunction

   task automatic clear_stats();
      pend_count = 0; pend_needed = 0;
      cp_total = 0; sent_total = 0; word_total = 0; space_total = 0;
      filled_total = 0; quoted_total = 0;
      sent_open = 0; in_word = 0; in_space = 0;
      line_content = 0; marker_done = 0; line_quoted = 0;
   endtask

   task automatic take_cp(input logic [20:0] cp, input logic marker);
      logic term, ws;
      term = cp == CP_DOT || cp == CP_BANG || cp == CP_QMARK || cp == CP_IDEO_DOT ||
             cp == CP_FW_BANG || cp == CP_FW_QMARK;
      ws = is_blank(cp) || cp == CP_IDEO_SP;
      cp_total = bump(cp_total);
      if (term) begin
         if (sent_open) begin
            sent_total = bump(sent_total);
            sent_open = 0;
         end
      end else if (!ws) begin
         sent_open = 1;
      end
      if (marker && !marker_done &&
          !(cp == CP_SPACE || cp == CP_TAB || cp == CP_CR || cp == CP_IDEO_SP)) begin
         marker_done = 1;
         line_quoted = cp == CP_DQUOTE || cp == CP_SQUOTE || cp == CP_LDQUOTE ||
                       cp == CP_CORNER || cp == CP_WCORNER;
      end
   endtask

   task automatic flush_pend();
      for (int i = 0; i < pend_count && i < 3; i++) take_cp({13'd0, pend_bytes[i]}, 1'b1);
      pend_count = 0;
      pend_needed = 0;
   endtask

   task automatic close_line();
      if (line_content) begin
         filled_total = bump(filled_total);
         if (line_quoted) quoted_total = bump(quoted_total);
      end
      line_content = 0; marker_done = 0; line_quoted = 0;
   endtask

   task automatic decode(input logic [7:0] b);
      logic [20:0] cp;
      if (pend_count > 0) begin
         if ((b & MASK_CONT) == CODE_CONT) begin
            if (pend_count >= pend_needed || pend_count >= 3) begin
               if (pend_needed == 1)
                  cp = {10'd0, pend_bytes[0][4:0], b[5:0]};
               else if (pend_needed == 2)
                  cp = {5'd0, pend_bytes[0][3:0], pend_bytes[1][5:0], b[5:0]};
               else
                  cp = {pend_bytes[0][2:0], pend_bytes[1][5:0], pend_bytes[2][5:0], b[5:0]};
               pend_count = 0;
               pend_needed = 0;
               take_cp(cp, 1'b1);
            end else begin
               pend_bytes[pend_count] = b;
               pend_count++;
            end
            return;
         end
         flush_pend();
      end
      if (b < 8'h80) begin
         if ({13'd0, b} == CP_LF) begin
            take_cp({13'd0, b}, 1'b0);
            close_line();
         end else begin
            take_cp({13'd0, b}, 1'b1);
         end
         return;
      end
      if ((b & MASK_LEAD2) == CODE_LEAD2) pend_needed = 1;
      else if ((b & MASK_LEAD3) == CODE_LEAD3) pend_needed = 2;
      else if ((b & MASK_LEAD4) == CODE_LEAD4) pend_needed = 3;
      else begin
         take_cp({13'd0, b}, 1'b1);
         return;
      end
      pend_bytes[0] = b;
      pend_count = 1;
   endtask

   task automatic tally_byte(input logic [7:0] b);
      logic wordish;
      wordish = (b >= "0" && b <= "9") || (b >= "A" && b <= "Z") || (b >= "a" && b <= "z") ||
                {13'd0, b} == CP_USCORE || {13'd0, b} == CP_SQUOTE;
      if (wordish) begin
         if (!in_word) word_total = bump(word_total);
         in_word = 1;
      end else begin
         in_word = 0;
      end
      if (!is_blank({13'd0, b})) begin
         if (!in_space) space_total = bump(space_total);
         in_space = 1;
         line_content = 1;
      end else begin
         in_space = 0;
      end
   endtask

   function automatic logic [63:0] fixed_quotient(input logic [63:0] num, input logic [63:0] den,
                                                  input logic [63:0] maxval);
      logic [63:0] ip, rem, q;
      if (den == 0) return 0;
      ip = num / den;
      rem = num % den;
      if (ip > (maxval >> FRAC)) return maxval;
      q = ip << FRAC;
      for (int i = FRAC - 1; i >= 0; i--) begin
         rem = rem << 1;
         if (rem >= den) begin
            rem = rem - den;
            q[i] = 1'b1;
         end
      end
      return (q > maxval) ? maxval : q;
   endfunction

   task automatic finish_text();
      result_type r;
      logic [63:0] toks;
      logic [63:0] mean_q, share_q;
      flush_pend();
      if (sent_open) begin
         sent_total = bump(sent_total);
         sent_open = 0;
      end
      close_line();
      toks = (word_total > 0) ? word_total : space_total;
      r.codepoint_count = cp_total[31:0];
      r.sentences = sent_total[31:0];
      r.tokens = toks[31:0];
      r.filled_lines = filled_total[31:0];
      r.quoted_lines = quoted_total[31:0];
      mean_q = fixed_quotient(toks, sent_total, {16'd0, MEAN_MAX});
      share_q = fixed_quotient(quoted_total, filled_total, {47'd0, SHARE_MAX});
      r.mean_sentence_tokens = mean_q[47:0];
      r.quoted_line_share = share_q[16:0];
      stats_queue.push_back(r);
      clear_stats();
   endtask

   task automatic compare(input string name, input logic [63:0] exp, input logic [63:0] got);
      if (exp !== got) begin
         $display("%0t: mismatch in %s: expected %0d, actual %0d", $time, name, exp, got);
         fail_count++;
      end
   endtask

   initial begin
      fail_count = 0;
      pending_words = 0;
      clear_stats();
   end

   always @(posedge clock) begin
      result_type e;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            if (req_chan.byte_valid) begin
               tally_byte(req_chan.data_byte);
               decode(req_chan.data_byte);
            end
            if (req_chan.end_of_text) finish_text();
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (stats_queue.size() == 0) begin
               $display("%0t: unexpected statistics word", $time);
               fail_count++;
            end else begin
               e = stats_queue.pop_front();
               compare("codepoint_count", e.codepoint_count, rsp_chan.codepoint_count);
               compare("sentences", e.sentences, rsp_chan.sentences);
               compare("tokens", e.tokens, rsp_chan.tokens);
               compare("filled_lines", e.filled_lines, rsp_chan.filled_lines);
               compare("quoted_lines", e.quoted_lines, rsp_chan.quoted_lines);
               compare("mean_sentence_tokens", e.mean_sentence_tokens,
                       rsp_chan.mean_sentence_tokens);
               compare("quoted_line_share", e.quoted_line_share, rsp_chan.quoted_line_share);
            end
         end
         pending_words = stats_queue.size();
      end
   end
endmodule

[tb/tb_utf8_text_statistics_engine_top.sv]
// Stimulus and verdict for the UTF-8 text statistics engine.
module tb_utf8_text_statistics_engine_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 1_000_000;

   logic clock = 0;
   logic reset = 1;
   int   fail_count, pending_words;
   int   send_idle_pct = 0, stall_pct = 0;
   logic hold_off = 0;
   int   cycles = 0;

   utsx_req_if req_chan ();
   utsx_rsp_if rsp_chan ();

   utf8_text_statistics_engine_top DUT (.clock(clock), .reset(reset),
                                        .req_chan(req_chan), .rsp_chan(rsp_chan));
   utsx_tb_checker checker_inst (.clock(clock), .reset(reset), .req_chan(req_chan),
                                 .rsp_chan(rsp_chan), .fail_count(fail_count),
                                 .pending_words(pending_words));

   always #4 clock = ~clock;

   initial begin
      req_chan.valid = 0;
      req_chan.data_byte = 0;
      req_chan.byte_valid = 0;
      req_chan.end_of_text = 0;
      rsp_chan.ready = 0;
   end

   // Receiver: random stalls, or a long hold-off while the sender keeps offering words.
   always @(negedge clock) begin
      rsp_chan.ready <= !hold_off && ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("** utf8_text_statistics_engine_top: FAILED **");
         $finish;
      end
   end

   // Valid stays up after a word so that the next one can follow without a gap.
   task automatic send_word(input logic [7:0] b, input logic bv, input logic eot);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 0;
         @(negedge clock);
      end
      req_chan.valid <= 1;
      req_chan.data_byte <= b;
      req_chan.byte_valid <= bv;
      req_chan.end_of_text <= eot;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic stop_sending();
      req_chan.valid <= 0;
      @(negedge clock);
   endtask

   task automatic send_text(input logic [7:0] txt [$]);
      foreach (txt[i]) send_word(txt[i], 1'b1, 1'b0);
      send_word(8'h00, 1'b0, 1'b1);
   endtask

   function automatic logic [7:0] pick_byte();
      int k;
      logic [7:0] s [$];
      k = $urandom_range(99);
      s = {" ", "\t", "\n", "\r", ".", "!", "?", "\"", "'", "_", 8'h0B, 8'h0C};
      if (k < 30) return 8'($urandom_range(8'h61, 8'h7A));
      if (k < 55) return s[$urandom_range(s.size() - 1)];
      if (k < 65) return 8'($urandom_range(8'h30, 8'h5A));
      if (k < 85) return 8'($urandom_range(8'h80, 8'hBF));
      if (k < 95) return 8'($urandom_range(8'hC0, 8'hF7));
      return 8'($urandom_range(255));
   endfunction

   // Mostly well-formed multibyte codepoints, including the special ones, with noise.
   task automatic add_random(ref logic [7:0] t [$]);
      int k;
      k = $urandom_range(9);
      case (k)
         0: t = {t, 8'hE3, 8'h80, 8'h82};
         1: t = {t, 8'hE2, 8'h80, 8'h9C};
         2: t = {t, 8'hE3, 8'h80, 8'h80};
         3: t = {t, 8'hEF, 8'hBC, 8'h81};
         4: t = {t, 8'hC3, 8'($urandom_range(8'h80, 8'hBF))};
         5: t = {t, 8'hF0, 8'h9F, 8'($urandom_range(8'h80, 8'hBF)), 8'h80};
         default: t.push_back(pick_byte());
      endcase
   endtask

   task automatic run_phase(input int texts, input int idle_pct, input int stall);
      logic [7:0] t [$];
      int n;
      send_idle_pct = idle_pct;
      stall_pct = stall;
      repeat (texts) begin
         t = {};
         n = ($urandom_range(9) == 0) ? $urandom_range(60) : $urandom_range(12);
         while (t.size() < n) add_random(t);
         send_text(t);
         if ($urandom_range(7) == 0) send_word(8'($urandom), 1'b0, 1'b0);
      end
      stop_sending();
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      // Directed texts.
      send_word(8'hFF, 1'b0, 1'b1);
      send_text({"H", "i", ".", " ", "Y", "o", "u", "!", "\n", "\"", "Q", "?", "\n", "\n"});
      send_text({" ", "\t", "\r", "'", "x", "\n", 8'hE3, 8'h80, 8'h80, 8'hE3, 8'h80, 8'h8C});
      send_text({8'hE2, 8'h80, 8'h9C, 8'hEF, 8'hBC, 8'h9F, 8'hE3, 8'h80, 8'h8E, "a"});
      send_text({8'hC0, 8'h8A, "z", 8'hF0, 8'h80, "b", 8'hE0, 8'hFF, 8'h80, 8'hF8});
      send_text({"%", " ", "&", 8'h0B, 8'h0C, ".", "!"});
      send_text({"a", 8'hF4, 8'h8F, 8'hBF});
      send_text({8'h00, 8'h7F});
      // Random phases with different idling.
      run_phase(30, 0, 0);
      run_phase(30, 71, 0);
      run_phase(30, 0, 71);
      run_phase(30, 29, 29);
      // Long receiver hold-off while texts keep coming.
      hold_off = 1;
      fork
         begin
            repeat (400) @(posedge clock);
            hold_off = 0;
         end
         run_phase(15, 0, 0);
      join
      while (pending_words != 0) @(posedge clock);
      @(negedge clock);
      run_phase(20, 0, 0);
      repeat (200) @(posedge clock);
      while (pending_words != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (fail_count == 0)
         $display("** utf8_text_statistics_engine_top: PASSED **");
      else
         $display("** utf8_text_statistics_engine_top: FAILED **");
      $finish;
   end
endmodule
